[rtl/atf_pkg.sv]
// Shared constants of the adaptive threshold filter.
package atf_pkg;

   localparam int RESIDUAL_BITS = 16;

endpackage

[rtl/atf_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module atf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   localparam int AddrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AddrBits-1:0] wr_addr,
   input  logic [WIDTH-1:0]    wr_data,
   input  logic [AddrBits-1:0] rd_addr,
   output logic [WIDTH-1:0]    rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/atf_divider.sv]
// Bit-serial restoring divider that yields one quotient bit per cycle.
module atf_divider #(
   parameter int DIVIDEND_BITS = 20,
   parameter int DIVISOR_BITS  = 5
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [DIVIDEND_BITS-1:0] dividend,
   input  logic [DIVISOR_BITS-1:0]  divisor,
   output logic                     done,
   output logic [DIVIDEND_BITS-1:0] quotient
);

   localparam int RemBits = DIVISOR_BITS + 1;
   localparam int CntBits = $clog2(DIVIDEND_BITS + 1);

   logic [DIVIDEND_BITS-1:0] quo_ff, quo_in;
   logic [RemBits-1:0]       rem_ff, rem_in;
   logic [DIVISOR_BITS-1:0]  div_ff, div_in;
   logic [CntBits-1:0]       cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [RemBits:0]         trial;
   logic                     fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[DIVIDEND_BITS-1]};
      fits    = trial >= (RemBits + 1)'(div_ff);
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = CntBits'(DIVIDEND_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? RemBits'(trial - (RemBits + 1)'(div_ff)) : RemBits'(trial);
         quo_in = {quo_ff[DIVIDEND_BITS-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntBits'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[rtl/adaptive_threshold_filter.sv]
// Top level of the adaptive threshold filter: sample ring, serial sum, divide and output.
//
//   channel | direction | ports                                   | word
//   req     | in        | req_valid req_stall req_sample_in       | one sample
//           |           | req_frame_end                           |
//   rsp     | out       | rsp_valid rsp_stall rsp_residual_out    | one residual
//           |           | rsp_last_out                            |
//
// A sample that yields no residual leaves the block idle for the next sample. Each
// residual averages a window of samples (up to PRE_TAPS + POST_TAPS + 1, one RAM
// read each) and divides their SUM_BITS-wide sum in the bit-serial divider.
// The last sample of a frame yields up to POST_TAPS + 1 residuals back to back.
// Reset is synchronous and needs no clearing pass.
// A stalled result is held in the output register while the next one is worked out.
module adaptive_threshold_filter
   import atf_pkg::*;
#(
   parameter int PRE_TAPS    = 8,
   parameter int POST_TAPS   = 7,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [SAMPLE_BITS-1:0]   req_sample_in,
   input  logic                     req_frame_end,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [RESIDUAL_BITS-1:0] rsp_residual_out,
   output logic                     rsp_last_out
);

   localparam int Depth   = PRE_TAPS + POST_TAPS + 1;
   localparam int AddrBits = $clog2(Depth);
   localparam int CntBits = $clog2(Depth + 1);
   localparam int SumBits = SAMPLE_BITS + $clog2(Depth);
   localparam int WideBits = (SAMPLE_BITS > RESIDUAL_BITS) ? SAMPLE_BITS : RESIDUAL_BITS;

   typedef enum logic [2:0] {
      IDLE,
      START,
      SUM,
      DRAIN,
      LAUNCH,
      DIVIDE,
      RESULT
   } state_type;

   state_type                state_ff, state_in;
   logic [AddrBits-1:0]      head_ff, head_in;
   logic [CntBits-1:0]       seen_ff, seen_in;
   logic [CntBits-1:0]       lim_ff, lim_in;
   logic [CntBits-1:0]       k_ff, k_in;
   logic                     flush_ff, flush_in;
   logic [CntBits-1:0]       deepest_ff, deepest_in;
   logic [CntBits-1:0]       o_ff, o_in;
   logic [AddrBits-1:0]      rd_ptr_ff, rd_ptr_in;
   logic                     pend_ff, pend_in;
   logic                     pend_k_ff, pend_k_in;
   logic [SumBits-1:0]       acc_ff, acc_in;
   logic [SAMPLE_BITS-1:0]   s_ff, s_in;
   logic [SAMPLE_BITS-1:0]   mean_ff, mean_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RESIDUAL_BITS-1:0] rsp_res_ff, rsp_res_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic                     accept;
   logic [AddrBits-1:0]      head_next;
   logic [CntBits-1:0]       seen_next;
   logic [CntBits-1:0]       k_reach;
   logic [SAMPLE_BITS-1:0]   rd_data;
   logic                     div_start;
   logic                     div_done;
   logic [SumBits-1:0]       quotient;
   logic [SAMPLE_BITS-1:0]   diff;
   logic [WideBits-1:0]      diff_wide;
   logic                     out_free;

   atf_ram #(
      .WIDTH(SAMPLE_BITS),
      .DEPTH(Depth)
   ) u_ring (
      .clock  (clock),
      .wr_en  (accept),
      .wr_addr(head_next),
      .wr_data(req_sample_in),
      .rd_addr(rd_ptr_ff),
      .rd_data(rd_data)
   );

   atf_divider #(
      .DIVIDEND_BITS(SumBits),
      .DIVISOR_BITS (CntBits)
   ) u_divider (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(acc_ff),
      .divisor (deepest_ff + 1'b1),
      .done    (div_done),
      .quotient(quotient)
   );

   assign accept    = req_valid && !req_stall;
   assign req_stall = state_ff != IDLE;
   assign div_start = state_ff == LAUNCH;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign head_next = (head_ff == AddrBits'(Depth - 1)) ? '0 : head_ff + 1'b1;
   assign seen_next = (seen_ff == CntBits'(Depth)) ? seen_ff : seen_ff + 1'b1;
   assign diff      = (s_ff > mean_ff) ? s_ff - mean_ff : '0;
   assign diff_wide = WideBits'(diff);

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      seen_in      = seen_ff;
      lim_in       = lim_ff;
      k_in         = k_ff;
      flush_in     = flush_ff;
      deepest_in   = deepest_ff;
      o_in         = o_ff;
      rd_ptr_in    = rd_ptr_ff;
      pend_in      = pend_ff;
      pend_k_in    = pend_k_ff;
      acc_in       = acc_ff;
      s_in         = s_ff;
      mean_in      = mean_ff;
      rsp_res_in   = rsp_res_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      k_reach      = k_ff + CntBits'(PRE_TAPS);

      unique case (state_ff)
         IDLE: begin
            if (accept) begin
               head_in  = head_next;
               lim_in   = seen_next - 1'b1;
               flush_in = req_frame_end;
               if (req_frame_end) begin
                  seen_in  = '0;
                  k_in     = (seen_next - 1'b1 < CntBits'(POST_TAPS)) ?
                             seen_next - 1'b1 : CntBits'(POST_TAPS);
                  state_in = START;
               end else begin
                  seen_in = seen_next;
                  k_in    = CntBits'(POST_TAPS);
                  if (seen_next > CntBits'(POST_TAPS)) begin
                     state_in = START;
                  end
               end
            end
         end
         START: begin
            deepest_in = (k_reach < lim_ff) ? k_reach : lim_ff;
            o_in       = '0;
            rd_ptr_in  = head_ff;
            acc_in     = '0;
            pend_in    = 1'b0;
            state_in   = SUM;
         end
         SUM: begin
            if (pend_ff) begin
               acc_in = acc_ff + SumBits'(rd_data);
               if (pend_k_ff) begin
                  s_in = rd_data;
               end
            end
            pend_in   = 1'b1;
            pend_k_in = o_ff == k_ff;
            rd_ptr_in = (rd_ptr_ff == '0) ? AddrBits'(Depth - 1) : rd_ptr_ff - 1'b1;
            o_in      = o_ff + 1'b1;
            if (o_ff == deepest_ff) begin
               state_in = DRAIN;
            end
         end
         DRAIN: begin
            acc_in  = acc_ff + SumBits'(rd_data);
            if (pend_k_ff) begin
               s_in = rd_data;
            end
            pend_in  = 1'b0;
            state_in = LAUNCH;
         end
         LAUNCH: begin
            state_in = DIVIDE;
         end
         DIVIDE: begin
            if (div_done) begin
               mean_in  = quotient[SAMPLE_BITS-1:0];
               state_in = RESULT;
            end
         end
         RESULT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_res_in   = diff_wide[RESIDUAL_BITS-1:0];
               rsp_last_in  = flush_ff && (k_ff == '0);
               if (!flush_ff || k_ff == '0) begin
                  state_in = IDLE;
               end else begin
                  k_in     = k_ff - 1'b1;
                  state_in = START;
               end
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         head_ff      <= '0;
         seen_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         seen_ff      <= seen_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lim_ff      <= lim_in;
      k_ff        <= k_in;
      flush_ff    <= flush_in;
      deepest_ff  <= deepest_in;
      o_ff        <= o_in;
      rd_ptr_ff   <= rd_ptr_in;
      pend_k_ff   <= pend_k_in;
      acc_ff      <= acc_in;
      s_ff        <= s_in;
      mean_ff     <= mean_in;
      rsp_res_ff  <= rsp_res_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_residual_out = rsp_res_ff;
   assign rsp_last_out     = rsp_last_ff;

endmodule
